FILE: sv/dfr_pkg.sv
// package for the six-axis packet deframer: framing codes, sizes, key masks,
// the queued packet type and the result type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    // framing bytes
    localparam logic [7:0] HDR_MOTION = 8'h44;
    localparam logic [7:0] HDR_KEY    = 8'h4B;
    localparam logic [7:0] END_MARK   = 8'h0D;

    // payload store and byte counter
    localparam int unsigned PAYLOAD_DEPTH = 14;
    localparam int unsigned COUNT_W       = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;
    localparam logic [COUNT_W-1:0] STORE_LIMIT = 4'd14;
    localparam logic [COUNT_W-1:0] MOTION_LEN  = 4'd14;
    localparam logic [COUNT_W-1:0] KEY_MIN_LEN = 4'd2;

    // queue between collector and decoder
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = 1;
    localparam int unsigned QCNT_W = 2;

    // key word masks
    localparam logic [15:0] PICK_MASK = 16'h1000;
    localparam logic [15:0] BTN_MASK [8] = '{
        16'h0001, 16'h0002, 16'h0004, 16'h0008,
        16'h0100, 16'h0200, 16'h0400, 16'h0800
    };

    // result packing widths
    localparam int unsigned RESULT_BITS = 121;
    localparam int unsigned TDATA_W     = 128;

    typedef enum logic {
        KIND_KEY    = 1'b0,
        KIND_MOTION = 1'b1
    } kind_t;

    // one complete packet handed from the front to the back
    typedef struct packed {
        kind_t                          kind;
        logic [PAYLOAD_DEPTH-1:0][7:0]  bytes;
    } packet_t;

    // one decoded result, fields in tdata order from the top down
    typedef struct packed {
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_x;
        logic signed [15:0] trans_z;
        logic signed [15:0] trans_y;
        logic signed [15:0] trans_x;
        logic [15:0]        period_sixteenths;
        logic [7:0]         button_flags;
        logic               pick_pressed;
    } result_t;

    function automatic logic [7:0] key_buttons(input logic [15:0] kw);
        logic [7:0] flags;
        flags = '0;
        for (int j = 0; j < 8; j++) begin
            flags[j] = |(kw & BTN_MASK[j]);
        end
        return flags;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dfr_front.sv
// byte collector: hunts for a header, stores payload, checks length on the
// end mark and pushes complete packets; uses dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_front
    import dfr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic    in_error,
    output logic         push_valid,
    input  wire logic    push_ready,
    output packet_t      push_data
);

    logic                          collecting_reg, collecting_next;
    kind_t                         kind_reg, kind_next;
    logic [COUNT_W-1:0]            count_reg, count_next;
    logic [PAYLOAD_DEPTH-1:0][7:0] bytes_reg;
    logic                          accept;
    logic                          is_end;
    logic                          store_en;
    logic                          len_ok;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;
    assign is_end   = (in_byte == END_MARK);
    assign store_en = accept && !in_error && collecting_reg && !is_end
                      && (count_reg < STORE_LIMIT);

    always_comb begin
        if (kind_reg == KIND_MOTION) begin
            len_ok = (count_reg == MOTION_LEN);
        end else begin
            len_ok = (count_reg >= KEY_MIN_LEN);
        end
    end

    assign push_valid      = accept && !in_error && collecting_reg && is_end && len_ok;
    assign push_data.kind  = kind_reg;
    assign push_data.bytes = bytes_reg;

    always_comb begin
        collecting_next = collecting_reg;
        kind_next       = kind_reg;
        count_next      = count_reg;
        if (accept) begin
            if (in_error) begin
                collecting_next = 1'b0;
                count_next      = '0;
            end else if (!collecting_reg) begin
                if (in_byte == HDR_MOTION || in_byte == HDR_KEY) begin
                    collecting_next = 1'b1;
                    kind_next       = (in_byte == HDR_MOTION) ? KIND_MOTION : KIND_KEY;
                    count_next      = '0;
                end
            end else if (is_end) begin
                collecting_next = 1'b0;
                count_next      = '0;
            end else if (count_reg < COUNT_MAX) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            kind_reg       <= KIND_KEY;
            count_reg      <= '0;
        end else begin
            collecting_reg <= collecting_next;
            kind_reg       <= kind_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            bytes_reg[count_reg] <= in_byte;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dfr_queue.sv
// two-entry packet queue between collector and decoder; uses dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_queue
    import dfr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  packet_t   push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output packet_t   pop_data
);

    packet_t            entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dfr_back.sv
// packet decoder and output register: turns a queued packet into key or
// motion fields; uses dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_back
    import dfr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  packet_t               pop_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_kind,
    output logic [TDATA_W-1:0]    out_data
);

    logic                  valid_reg, valid_next;
    kind_t                 kind_reg;
    result_t               result_reg;
    result_t               decoded;
    logic [15:0]           key_word;
    logic                  load;

    assign pop_ready = !valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;
    assign key_word  = {pop_data.bytes[0], pop_data.bytes[1]};

    always_comb begin
        decoded = '0;
        if (pop_data.kind == KIND_MOTION) begin
            decoded.period_sixteenths = {pop_data.bytes[0],  pop_data.bytes[1]};
            decoded.trans_x           = {pop_data.bytes[2],  pop_data.bytes[3]};
            decoded.trans_y           = {pop_data.bytes[4],  pop_data.bytes[5]};
            decoded.trans_z           = {pop_data.bytes[6],  pop_data.bytes[7]};
            decoded.rot_x             = {pop_data.bytes[8],  pop_data.bytes[9]};
            decoded.rot_y             = {pop_data.bytes[10], pop_data.bytes[11]};
            decoded.rot_z             = {pop_data.bytes[12], pop_data.bytes[13]};
        end else begin
            decoded.pick_pressed = |(key_word & PICK_MASK);
            decoded.button_flags = key_buttons(key_word);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= pop_data.kind;
            result_reg <= decoded;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = {{(TDATA_W - RESULT_BITS){1'b0}}, result_reg};

endmodule

`default_nettype wire

FILE: sv/six_axis_packet_deframer.sv
// top level of the six-axis packet deframer: collector, packet queue and
// decoder; uses dfr_pkg, dfr_front, dfr_queue and dfr_back
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one received serial byte per transfer on the slave
// stream and reports each complete packet as one transfer on the master
// stream. While hunting it ignores everything but a 'D' (motion) or 'K' (key)
// header; the bytes after a header are collected until a carriage return.
// A motion packet must carry exactly 14 payload bytes and yields a period in
// 1/16 ms units plus six signed big-endian axes; a key packet needs at least
// two payload bytes and yields the pick flag and eight button flags. Packets
// of the wrong length are dropped silently. A transfer with tuser set marks a
// link error: its byte is ignored and any partial packet is abandoned. Rate:
// one byte is taken every cycle; the only stall comes from the two-entry
// packet queue, which fills only when the master side holds off tready while
// more packets complete. From the carriage return a packet passes through the
// queue and then the output register before m_axis_tvalid rises. Unused fields
// of a result (axes of a key packet, flags of a motion packet) read as zero.
module six_axis_packet_deframer
    import dfr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // slave stream: received bytes
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  wire logic         s_axis_tuser,   // [0] link_error
    // master stream: decoded packets
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // [0] pick_pressed, [8:1] button_flags,
                                              // [24:9] period_sixteenths,
                                              // [40:25] trans_x, [56:41] trans_y,
                                              // [72:57] trans_z, [88:73] rot_x,
                                              // [104:89] rot_y, [120:105] rot_z,
                                              // [127:121] zero
    output logic              m_axis_tuser    // [0] packet_kind
);

    // front to queue
    logic    q_push_valid;
    logic    q_push_ready;
    packet_t q_push_data;
    // queue to back
    logic    q_pop_valid;
    logic    q_pop_ready;
    packet_t q_pop_data;

    // header hunt, payload collection, length check
    dfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_error   (s_axis_tuser),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    // decouples collection from output back-pressure
    dfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // field extraction into the output register
    dfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

    // a packet is only queued on an accepted, error-free end mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push_valid |-> (s_axis_tvalid && s_axis_tready && !s_axis_tuser
                          && s_axis_tdata == END_MARK))
        else $error("packet queued without an accepted end mark");

    // a packet leaving the queue shows up on the master side next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop_valid && q_pop_ready) |=> m_axis_tvalid)
        else $error("dequeued packet not presented");

    // key results carry no period or axes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_KEY) |-> (m_axis_tdata[127:9] == '0))
        else $error("key result with nonzero motion fields");

    // motion results carry no button flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_MOTION)
            |-> (m_axis_tdata[8:0] == '0 && m_axis_tdata[127:121] == '0))
        else $error("motion result with nonzero key fields");

endmodule

`default_nettype wire

FILE: test/six_axis_packet_deframer_tb.sv
// self-checking testbench for the six-axis packet deframer: byte stream in,
// decoded key and motion packets out, compared against an in-bench predictor
// depends on dfr_pkg and six_axis_packet_deframer
`timescale 1ns / 1ps

module six_axis_packet_deframer_tb;
    import dfr_pkg::*;

    localparam int unsigned BUSY_ITEMS   = 1600;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned MAX_GAP      = 10;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned NUM_STEPS    = 28;

    typedef struct packed {
        kind_t   kind;
        result_t res;
    } packet_out_t;

    // one directed transfer; typed rows carry their outcome, others use the predictor
    typedef struct packed {
        logic [7:0] rx;
        logic       err;
        logic       typed;
        logic       has_out;
        kind_t      kind;
        result_t    res;
    } step_row_t;

    localparam step_row_t STEPS [NUM_STEPS] = '{
        // carriage return while hunting
        '{END_MARK,   1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        // long key packet, all key bits set
        '{HDR_KEY,    1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{8'h00,      1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{END_MARK,   1'b0, 1'b1, 1'b1, KIND_KEY, 121'h1FF},
        // short key packet is dropped
        '{HDR_KEY,    1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{8'h00,      1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{END_MARK,   1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        // header byte as payload, then link error abandons the packet
        '{HDR_KEY,    1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{HDR_MOTION, 1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{END_MARK,   1'b1, 1'b1, 1'b0, KIND_KEY, '0},
        // motion packet with axis extremes
        '{HDR_MOTION, 1'b0, 1'b1, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h80,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h00,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h7F,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h00,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h00,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'hFF,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{HDR_KEY,    1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{HDR_MOTION, 1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h00,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{8'h01,      1'b0, 1'b0, 1'b0, KIND_KEY, '0},
        '{END_MARK,   1'b0, 1'b1, 1'b1, KIND_MOTION,
          {16'h0001, 16'h4B44, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
           8'h00, 1'b0}}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;

    // predictor state
    logic               in_packet;
    logic               motion_hdr;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         payload [PAYLOAD_DEPTH];

    packet_out_t        pending_packets [$];
    packet_out_t        got_packet;
    packet_out_t        want_packet;
    int unsigned        mismatches   = 0;
    int unsigned        busy_items   = 0;
    int unsigned        cycles       = 0;
    int unsigned        result_stall = 3;
    logic               tx_burst     = 1'b0;
    logic               rx_burst     = 1'b0;

    six_axis_packet_deframer i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one byte through the deframer state; decodes on the carriage return
    task automatic deframe_byte(input logic [7:0] rx, input logic err,
                                output logic has, output packet_out_t out);
        logic [15:0] kw;
        has = 1'b0;
        out = '0;
        if (err) begin
            in_packet  = 1'b0;
            byte_count = '0;
        end else if (!in_packet) begin
            if (rx == HDR_MOTION || rx == HDR_KEY) begin
                in_packet  = 1'b1;
                motion_hdr = (rx == HDR_MOTION);
                byte_count = '0;
            end
        end else if (rx == END_MARK) begin
            if (motion_hdr && byte_count == MOTION_LEN) begin
                has = 1'b1;
                out.kind = KIND_MOTION;
                out.res.period_sixteenths = {payload[0], payload[1]};
                out.res.trans_x = {payload[2], payload[3]};
                out.res.trans_y = {payload[4], payload[5]};
                out.res.trans_z = {payload[6], payload[7]};
                out.res.rot_x   = {payload[8], payload[9]};
                out.res.rot_y   = {payload[10], payload[11]};
                out.res.rot_z   = {payload[12], payload[13]};
            end else if (!motion_hdr && byte_count >= KEY_MIN_LEN) begin
                has = 1'b1;
                out.kind = KIND_KEY;
                kw = {payload[0], payload[1]};
                out.res.pick_pressed = |(kw & PICK_MASK);
                // buttons 5..8 sit in the low nibble of the upper byte
                out.res.button_flags = {kw[11:8], kw[3:0]};
            end
            in_packet  = 1'b0;
            byte_count = '0;
        end else begin
            if (byte_count < STORE_LIMIT) payload[byte_count] = rx;
            if (byte_count < COUNT_MAX) byte_count = byte_count + 1'b1;
        end
    endtask

    // drive one transfer at the falling edge, wait for acceptance, then predict
    task automatic send_byte(input logic [7:0] rx, input logic err,
                             output logic has, output packet_out_t out);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge aclk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = rx;
        s_axis_tuser  = err;
        do @(posedge aclk); while (!s_axis_tready);
        if (err || in_packet || rx == HDR_MOTION || rx == HDR_KEY) busy_items++;
        deframe_byte(rx, err, has, out);
    endtask

    task automatic feed_byte(input logic [7:0] rx, input logic err);
        logic        has;
        packet_out_t out;
        send_byte(rx, err, has, out);
        if (has) pending_packets = {pending_packets, out};
    endtask

    // payload content never holds the terminator
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            3: b = $urandom_range(0, 1) ? HDR_MOTION : HDR_KEY;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == END_MARK) b = ~b;
        return b;
    endfunction

    task automatic send_random_packet();
        int unsigned pick;
        int unsigned len;
        tx_burst = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // well-formed motion packet
            feed_byte(HDR_MOTION, 1'b0);
            repeat (MOTION_LEN) feed_byte(payload_byte(), 1'b0);
            feed_byte(END_MARK, 1'b0);
        end else if (pick < 70) begin
            // key packet, mostly long enough, sometimes too short
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            feed_byte(HDR_KEY, 1'b0);
            repeat (len) feed_byte(payload_byte(), 1'b0);
            feed_byte(END_MARK, 1'b0);
        end else if (pick < 80) begin
            // motion packet of the wrong length, including past saturation
            len = $urandom_range(0, 20);
            if (len == MOTION_LEN) len++;
            feed_byte(HDR_MOTION, 1'b0);
            repeat (len) feed_byte(payload_byte(), 1'b0);
            feed_byte(END_MARK, 1'b0);
        end else if (pick < 88) begin
            // line noise
            repeat ($urandom_range(1, 4)) feed_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            // packet cut short by a link error
            feed_byte($urandom_range(0, 1) ? HDR_MOTION : HDR_KEY, 1'b0);
            repeat ($urandom_range(0, 16)) feed_byte(payload_byte(), 1'b0);
            feed_byte(8'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 1)) feed_byte(END_MARK, 1'b0);
        end
    endtask

    function automatic string describe(packet_out_t p);
        return $sformatf("kind %0d pick %0d buttons %02h period %0d axes %0d %0d %0d %0d %0d %0d",
                         p.kind, p.res.pick_pressed, p.res.button_flags,
                         p.res.period_sixteenths, p.res.trans_x, p.res.trans_y,
                         p.res.trans_z, p.res.rot_x, p.res.rot_y, p.res.rot_z);
    endfunction

    // result side back-pressure; the stall counts only cycles with a result offered
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (result_stall != 0) begin
                m_axis_tready = 1'b0;
                if (m_axis_tvalid) result_stall--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_packet.kind = kind_t'(m_axis_tuser);
            got_packet.res  = m_axis_tdata[RESULT_BITS-1:0];
            if (pending_packets.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected packet at cycle %0d: %s", cycles, describe(got_packet));
            end else begin
                want_packet = pending_packets.pop_front();
                if (got_packet != want_packet || m_axis_tdata[TDATA_W-1:RESULT_BITS] != '0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("packet mismatch at cycle %0d (pad %h)", cycles,
                                 m_axis_tdata[TDATA_W-1:RESULT_BITS]);
                        $display("  expected %s", describe(want_packet));
                        $display("  actual   %s", describe(got_packet));
                    end
                end
            end
            if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
            result_stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned idx;
        logic        has;
        logic        paused;
        packet_out_t out;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        in_packet     = 1'b0;
        motion_hdr    = 1'b0;
        byte_count    = '0;
        paused        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (idx = 0; idx < NUM_STEPS; idx++) begin
            send_byte(STEPS[idx].rx, STEPS[idx].err, has, out);
            if (STEPS[idx].typed) begin
                has      = STEPS[idx].has_out;
                out.kind = STEPS[idx].kind;
                out.res  = STEPS[idx].res;
            end
            if (has) pending_packets = {pending_packets, out};
        end

        busy_items = 0;
        while (busy_items < BUSY_ITEMS) begin
            send_random_packet();
            // once midway, hold the input until every packet has come out
            if (!paused && busy_items >= BUSY_ITEMS / 2) begin
                paused = 1'b1;
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
                while (pending_packets.size() != 0) @(posedge aclk);
            end
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_packets.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_packets.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
